/* hw/rtl/circle_tile_collision_pushout_defines.svh */
// ----------------------------------------------------------------------------
// circle tile collision pushout assertion macros
// shared property wrappers, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef CIRCLE_TILE_COLLISION_PUSHOUT_DEFINES_SVH
`define CIRCLE_TILE_COLLISION_PUSHOUT_DEFINES_SVH

// same-cycle implication
`define CTCP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CTCP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/ctcp_pkg.sv */
// ----------------------------------------------------------------------------
// ctcp_pkg
// shared constants, state codes and controller/datapath interface structs
// ----------------------------------------------------------------------------
package ctcp_pkg;

	// map store and fixed point format
	localparam int MAP_SIDE  = 64;
	localparam int MAP_AW    = 6;
	localparam int FRAC_BITS = 8;
	localparam int ONE_TILE  = 1 << FRAC_BITS;

	// iteration counts of the shared units
	localparam int SQRT_STEPS = 10;
	localparam int DIV_STEPS  = 20;

	// item kinds carried in tuser
	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_RESOLVE = 1'b1;

	// register indexes
	localparam logic REG_MAP_WIDTH  = 1'b0;
	localparam logic REG_MAP_HEIGHT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_RD,
		ST_CHK,
		ST_SQ,
		ST_CMP,
		ST_SQRT,
		ST_PROD,
		ST_DIV,
		ST_ACC,
		ST_NEXT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic wr_tile;
		logic load;
		logic init;
		logic rd;
		logic sq;
		logic cmp;
		logic sqrt_step;
		logic prod;
		logic div_step;
		logic acc;
		logic adv;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic blocked;
		logic hit;
		logic last;
	} sts_t;

endpackage

/* hw/rtl/ctcp_datapath.sv */
// ----------------------------------------------------------------------------
// ctcp_datapath
// tile map, window scan registers, square root and divide units, push sums
// ----------------------------------------------------------------------------
module ctcp_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  ctcp_pkg::cmd_t    cmd,
	output ctcp_pkg::sts_t    sts,
	input  logic [55:0]       s_tdata,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_idx,
	input  logic [6:0]        cfg_data,
	output logic [31:0]       m_tdata
);
	import ctcp_pkg::*;

	// input word fields
	logic [5:0]         f_tile_x, f_tile_y;
	logic               f_walk, f_can;
	logic signed [15:0] f_px, f_py;
	logic [9:0]         f_r;

	assign f_tile_x = s_tdata[5:0];
	assign f_tile_y = s_tdata[11:6];
	assign f_walk   = s_tdata[12];
	assign f_px     = s_tdata[28:13];
	assign f_py     = s_tdata[44:29];
	assign f_r      = s_tdata[54:45];
	assign f_can    = s_tdata[55];

	logic [6:0]         mw_q, mh_q;
	logic               walk_mem [MAP_SIDE*MAP_SIDE];
	logic               rd_q, oob_q;
	logic signed [15:0] px_q, py_q;
	logic [9:0]         r_q;
	logic               can_q;
	logic [19:0]        r2_q;
	logic signed [9:0]  cx_q, cy_q, y0_q, x1_q, y1_q;
	logic signed [12:0] dx_q, dy_q;
	logic [21:0]        sqx_q, sqy_q;
	logic [19:0]        rem_q, root_q, bit_q;
	logic [9:0]         d_q;
	logic [19:0]        numx_q, numy_q;
	logic [9:0]         remx_q, remy_q;
	logic               sgnx_q, sgny_q;
	logic signed [29:0] sx_q, sy_q;
	logic [31:0]        out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mw_q <= 7'd64;
			mh_q <= 7'd64;
		end else if (cfg_we) begin
			if (cfg_idx == REG_MAP_WIDTH) mw_q <= cfg_data;
			if (cfg_idx == REG_MAP_HEIGHT) mh_q <= cfg_data;
		end
	end

	// window bounds
	logic signed [17:0] lox, loy, hix, hiy;
	assign lox = 18'(px_q) - $signed({8'd0, r_q}) - 18'sd256;
	assign loy = 18'(py_q) - $signed({8'd0, r_q}) - 18'sd256;
	assign hix = 18'(px_q) + $signed({8'd0, r_q}) + 18'sd511;
	assign hiy = 18'(py_q) + $signed({8'd0, r_q}) + 18'sd511;

	// nearest point of the current tile square
	logic signed [17:0] pxe, pye, xl, xh, yl, yh, nx, ny, dxw, dyw;
	assign pxe = 18'(px_q);
	assign pye = 18'(py_q);
	assign xl  = {cx_q, 8'd0};
	assign yl  = {cy_q, 8'd0};
	assign xh  = xl + 18'sd256;
	assign yh  = yl + 18'sd256;
	assign nx  = (pxe < xl) ? xl : ((pxe > xh) ? xh : pxe);
	assign ny  = (pye < yl) ? yl : ((pye > yh) ? yh : pye);
	assign dxw = pxe - nx;
	assign dyw = pye - ny;

	logic in_bounds;
	assign in_bounds = (cx_q >= 10'sd0) && (cy_q >= 10'sd0)
		&& (cx_q < $signed({3'd0, mw_q})) && (cy_q < $signed({3'd0, mh_q}))
		&& (cx_q < 10'sd64) && (cy_q < 10'sd64);

	// tile map, written by tile words, read one tile per scan step
	always_ff @(posedge clk) begin
		if (cmd.wr_tile) walk_mem[{f_tile_y, f_tile_x}] <= f_walk;
		if (cmd.rd) rd_q <= walk_mem[{cy_q[MAP_AW-1:0], cx_q[MAP_AW-1:0]}];
	end

	// squared distance and hit test
	logic [22:0] d2;
	assign d2 = {1'b0, sqx_q} + {1'b0, sqy_q};

	// square root step
	logic [20:0] sq_t;
	assign sq_t = {1'b0, root_q} + {1'b0, bit_q};

	// divide steps
	logic [10:0] trx, try_;
	assign trx  = {remx_q, numx_q[19]};
	assign try_ = {remy_q, numy_q[19]};

	// push products
	logic [9:0] rmd, adx, ady;
	logic [12:0] ndx, ndy;
	assign ndx = -dx_q;
	assign ndy = -dy_q;
	assign rmd = r_q - root_q[9:0];
	assign adx = dx_q[12] ? ndx[9:0] : dx_q[9:0];
	assign ady = dy_q[12] ? ndy[9:0] : dy_q[9:0];

	// final sum and saturation
	logic signed [30:0] tx, ty;
	logic [15:0] satx, saty;
	assign tx = 31'(px_q) + 31'(sx_q);
	assign ty = 31'(py_q) + 31'(sy_q);
	assign satx = (tx > 31'sd32767) ? 16'h7FFF : ((tx < -31'sd32768) ? 16'h8000 : tx[15:0]);
	assign saty = (ty > 31'sd32767) ? 16'h7FFF : ((ty < -31'sd32768) ? 16'h8000 : ty[15:0]);

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q  <= f_px;
			py_q  <= f_py;
			r_q   <= f_r;
			can_q <= f_can;
			sx_q  <= '0;
			sy_q  <= '0;
		end
		if (cmd.init) begin
			cx_q <= lox[17:8];
			cy_q <= loy[17:8];
			y0_q <= loy[17:8];
			x1_q <= hix[17:8];
			y1_q <= hiy[17:8];
			r2_q <= r_q * r_q;
		end
		if (cmd.rd) begin
			oob_q <= !in_bounds;
			dx_q  <= dxw[12:0];
			dy_q  <= dyw[12:0];
		end
		if (cmd.sq) begin
			sqx_q <= 22'(dx_q * dx_q);
			sqy_q <= 22'(dy_q * dy_q);
		end
		if (cmd.cmp) begin
			rem_q  <= d2[19:0];
			root_q <= '0;
			bit_q  <= 20'h40000;
		end
		if (cmd.sqrt_step) begin
			if ({1'b0, rem_q} >= sq_t) begin
				rem_q  <= rem_q - sq_t[19:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.prod) begin
			numx_q <= rmd * adx;
			numy_q <= rmd * ady;
			remx_q <= '0;
			remy_q <= '0;
			sgnx_q <= dx_q[12];
			sgny_q <= dy_q[12];
			d_q    <= root_q[9:0];
		end
		if (cmd.div_step) begin
			if (trx >= {1'b0, d_q}) begin
				remx_q <= 10'(trx - {1'b0, d_q});
				numx_q <= {numx_q[18:0], 1'b1};
			end else begin
				remx_q <= trx[9:0];
				numx_q <= {numx_q[18:0], 1'b0};
			end
			if (try_ >= {1'b0, d_q}) begin
				remy_q <= 10'(try_ - {1'b0, d_q});
				numy_q <= {numy_q[18:0], 1'b1};
			end else begin
				remy_q <= try_[9:0];
				numy_q <= {numy_q[18:0], 1'b0};
			end
		end
		if (cmd.acc) begin
			sx_q <= sgnx_q ? sx_q - $signed({10'd0, numx_q}) : sx_q + $signed({10'd0, numx_q});
			sy_q <= sgny_q ? sy_q - $signed({10'd0, numy_q}) : sy_q + $signed({10'd0, numy_q});
		end
		if (cmd.adv) begin
			if (cy_q == y1_q) begin
				cy_q <= y0_q;
				cx_q <= cx_q + 10'sd1;
			end else begin
				cy_q <= cy_q + 10'sd1;
			end
		end
		if (cmd.out_ld) out_q <= {saty, satx};
	end

	// status to controller
	assign sts.active  = can_q && (r_q != 10'd0);
	assign sts.blocked = oob_q || !rd_q;
	assign sts.hit     = (d2 != 23'd0) && (d2 < {3'd0, r2_q});
	assign sts.last    = (cx_q == x1_q) && (cy_q == y1_q);

	assign m_tdata = out_q;

endmodule

/* hw/rtl/ctcp_ctrl.sv */
// ----------------------------------------------------------------------------
// ctcp_ctrl
// sequencer for the tile scan, unit iterations and the output word register
// ----------------------------------------------------------------------------
module ctcp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [0:0]     s_tuser,
	output logic           m_tvalid,
	input  logic           m_tready,
	output ctcp_pkg::cmd_t cmd,
	input  ctcp_pkg::sts_t sts
);
	import ctcp_pkg::*;

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic       oval_q;

	// state and iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) oval_q <= 1'b0;
		else if (cmd.out_ld) oval_q <= 1'b1;
		else if (m_tready) oval_q <= 1'b0;
	end

	assign m_tvalid = oval_q;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser[0] == OP_RESOLVE) begin
						cmd.load = 1'b1;
						state_d  = ST_INIT;
					end else begin
						cmd.wr_tile = 1'b1;
					end
				end
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d  = sts.active ? ST_RD : ST_FIN;
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_CHK;
			end
			ST_CHK: state_d = sts.blocked ? ST_SQ : ST_NEXT;
			ST_SQ: begin
				cmd.sq  = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				cnt_d   = 5'(SQRT_STEPS - 1);
				state_d = sts.hit ? ST_SQRT : ST_NEXT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d = cnt_q - 5'd1;
				if (cnt_q == 5'd0) state_d = ST_PROD;
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				cnt_d    = 5'(DIV_STEPS - 1);
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q - 5'd1;
				if (cnt_q == 5'd0) state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = ST_NEXT;
			end
			ST_NEXT: begin
				if (sts.last) begin
					state_d = ST_FIN;
				end else begin
					cmd.adv = 1'b1;
					state_d = ST_RD;
				end
			end
			ST_FIN: begin
				if (!oval_q || m_tready) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* hw/rtl/circle_tile_collision_pushout.sv */
// ----------------------------------------------------------------------------
// circle_tile_collision_pushout
// pushes a circular unit out of blocked tiles of a 64 x 64 walkability map
// ----------------------------------------------------------------------------
// A tile-write word (tuser 0) is taken while the block is idle and gives no
// result. A resolve word (tuser 1) scans its tile window one tile at a time:
// a walkable tile is read and checked, a blocked tile out of reach also has
// its squared distance compared, and a blocked tile that overlaps the circle
// further runs a 10-step square root and a 20-step divide for both axes.
// Immobile or zero-radius units skip the scan. The block holds one resolve at
// a time; a finished result waits in an output register while the next word
// is taken.
module circle_tile_collision_pushout (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tile_x, tile_y, tile_walkable, pos_x, pos_y, radius, can_move
	input  logic [55:0] s_tdata,
	// op
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// new_x, new_y
	output logic [31:0] m_tdata,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [6:0]  cfg_data
);
	import ctcp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	ctcp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// arithmetic and map
	ctcp_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.m_tdata  (m_tdata)
	);

endmodule

/* hw/rtl/ctcp_checker.sv */
// ----------------------------------------------------------------------------
// ctcp_checker
// port-level checks of the pushout block, bound to the top level
// ----------------------------------------------------------------------------
`include "circle_tile_collision_pushout_defines.svh"

module ctcp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// stalled result word holds
	`CTCP_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped")
	`CTCP_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result word changed")
	// a resolve occupies the block
	`CTCP_ASSERT_NXT(a_busy, s_tvalid && s_tready && s_tuser[0], !s_tready, "ready during resolve")
	// a new result only comes out of a busy cycle
	`CTCP_ASSERT_IMP(a_rise, $rose(m_tvalid), $past(!s_tready), "result without resolve")

endmodule

bind circle_tile_collision_pushout ctcp_checker u_chk (.*);

/* tb/circle_tile_collision_pushout_tb.sv */
// ----------------------------------------------------------------------------
// circle_tile_collision_pushout_tb
// loads the walkability map, then streams tile writes and unit resolves with
// random idling on both sides; a scoreboard predicts each resolved centre
// ----------------------------------------------------------------------------
module circle_tile_collision_pushout_tb;
	import ctcp_pkg::*;

	// side of the loaded corner of the map; resolve windows stay inside it
	// or fully beyond the store
	localparam int LOAD_SIDE = 32;

	// predicts resolved centres and holds them until the block returns them
	class pushout_scoreboard;
		bit                 walk_map [MAP_SIDE*MAP_SIDE];
		longint             map_w = 64;
		longint             map_h = 64;
		logic [31:0]        centre_q[$];
		int                 errors = 0;

		function void set_reg(logic idx, logic [6:0] val);
			if (idx == REG_MAP_WIDTH)
				map_w = val;
			else
				map_h = val;
		endfunction

		function longint unsigned root_floor(longint unsigned v);
			longint unsigned res;
			longint unsigned b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function longint clampl(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function bit is_blocked(longint x, longint y);
			longint w;
			longint h;
			w = map_w < MAP_SIDE ? map_w : MAP_SIDE;
			h = map_h < MAP_SIDE ? map_h : MAP_SIDE;
			if (x < 0 || y < 0 || x >= w || y >= h)
				return 1;
			return !walk_map[y*MAP_SIDE + x];
		endfunction

		// floor of a fixed point value in whole tiles
		function longint tile_floor(longint a);
			return a >>> FRAC_BITS;
		endfunction

		function void note_word(logic [0:0] kind, logic [55:0] d);
			longint px, py, r, sx, sy, x, y, nx, ny, dx, dy, d2, dd;
			longint x0, x1, y0, y1;
			if (kind == OP_WRITE) begin
				walk_map[d[11:6]*MAP_SIDE + d[5:0]] = d[12];
				return;
			end
			px = longint'($signed(d[28:13]));
			py = longint'($signed(d[44:29]));
			r = d[54:45];
			sx = 0;
			sy = 0;
			if (d[55] && r > 0) begin
				x0 = tile_floor(px - r - ONE_TILE);
				x1 = -tile_floor(-(px + r + ONE_TILE));
				y0 = tile_floor(py - r - ONE_TILE);
				y1 = -tile_floor(-(py + r + ONE_TILE));
				for (x = x0; x <= x1; x++) begin
					for (y = y0; y <= y1; y++) begin
						if (!is_blocked(x, y))
							continue;
						nx = clampl(px, x*ONE_TILE, (x+1)*ONE_TILE);
						ny = clampl(py, y*ONE_TILE, (y+1)*ONE_TILE);
						dx = px - nx;
						dy = py - ny;
						d2 = dx*dx + dy*dy;
						if (d2 == 0 || d2 >= r*r)
							continue;
						dd = longint'(root_floor(d2));
						if (dd <= 0)
							continue;
						sx += ((r - dd) * dx) / dd;
						sy += ((r - dd) * dy) / dd;
					end
				end
			end
			centre_q.push_back({16'(clampl(py + sy, -32768, 32767)),
				16'(clampl(px + sx, -32768, 32767))});
		endfunction

		function void check_word(logic [31:0] got);
			logic [31:0] exp_c;
			if (centre_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp_c = centre_q.pop_front();
			if (got[15:0] !== exp_c[15:0]) begin
				$display("%0t: new_x expected %h actual %h", $time, exp_c[15:0], got[15:0]);
				errors++;
			end
			if (got[31:16] !== exp_c[31:16]) begin
				$display("%0t: new_y expected %h actual %h", $time, exp_c[31:16],
					got[31:16]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	// tile_x, tile_y, tile_walkable, pos_x, pos_y, radius, can_move
	logic [55:0] s_tdata = '0;
	// op
	logic [0:0]  s_tuser = OP_WRITE;
	logic        m_tvalid;
	logic        m_tready = 0;
	// new_x, new_y
	logic [31:0] m_tdata;
	logic        cfg_we = 0;
	logic [0:0]  cfg_idx = REG_MAP_WIDTH;
	logic [6:0]  cfg_data = '0;

	pushout_scoreboard sb = new();
	bit idling = 1;

	circle_tile_collision_pushout dut (.*);

	always #5 clk = ~clk;

	// result side: random stalls, check each accepted word
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_word(m_tdata);
		m_tready <= !(idling && $urandom_range(99) < 15);
	end

	task automatic send_word(logic [0:0] kind, logic [55:0] d);
		while (idling && $urandom_range(99) < 15) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		sb.note_word(kind, d);
	endtask

	function automatic logic [55:0] write_word(int tx, int ty, bit walk);
		logic [55:0] d;
		d = '0;
		d[5:0] = 6'(tx);
		d[11:6] = 6'(ty);
		d[12] = walk;
		d[28:13] = 16'($urandom);
		d[54:45] = 10'($urandom);
		d[55] = 1'($urandom);
		return d;
	endfunction

	function automatic logic [55:0] resolve_word(int px, int py, int r, bit mv);
		logic [55:0] d;
		d = '0;
		d[11:0] = 12'($urandom);
		d[12] = 1'($urandom);
		d[28:13] = 16'(px);
		d[44:29] = 16'(py);
		d[54:45] = 10'(r);
		d[55] = mv;
		return d;
	endfunction

	// drain, let the block settle, then write a register
	task automatic write_reg(logic idx, logic [6:0] val);
		s_tvalid <= 0;
		while (sb.centre_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
	endtask

	// one coordinate whose window lies in the loaded corner or beyond the store
	function automatic int pick_coord(int sel);
		int c;
		if (sel < 70)
			c = $urandom_range(6600);
		else if (sel < 85)
			c = $urandom_range(7624) - 1024;
		else if ($urandom_range(1) == 1)
			c = 17664 + $urandom_range(15103);
		else
			c = -int'($urandom_range(32768));
		return c;
	endfunction

	task automatic random_item();
		int px, py, r, sel;
		if ($urandom_range(99) < 25) begin
			send_word(OP_WRITE, write_word($urandom_range(LOAD_SIDE - 1),
				$urandom_range(LOAD_SIDE - 1), $urandom_range(99) < 80));
			return;
		end
		sel = $urandom_range(99);
		px = pick_coord(sel);
		py = pick_coord(sel);
		r = ($urandom_range(99) < 90) ? $urandom_range(400) : $urandom_range(1023);
		send_word(OP_RESOLVE, resolve_word(px, py, r, $urandom_range(99) < 90));
	endtask

	initial begin
		#1000000000;
		$display("circle_tile_collision_pushout: mismatch");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// load the corner of the store that resolve windows can reach
		for (int ty = 0; ty < LOAD_SIDE; ty++)
			for (int tx = 0; tx < LOAD_SIDE; tx++)
				send_word(OP_WRITE, write_word(tx, ty, $urandom_range(99) < 80));

		// directed: extremes and special cases
		send_word(OP_WRITE, write_word(63, 63, 1));
		send_word(OP_WRITE, write_word(5, 5, 0));
		send_word(OP_WRITE, write_word(6, 5, 1));
		send_word(OP_RESOLVE, resolve_word(5*256 + 128, 5*256 + 128, 300, 1));
		send_word(OP_RESOLVE, resolve_word(6*256 + 20, 5*256 + 128, 200, 1));
		send_word(OP_RESOLVE, resolve_word(1000, 1000, 0, 1));
		send_word(OP_RESOLVE, resolve_word(1000, 1000, 1023, 0));
		send_word(OP_RESOLVE, resolve_word(4096, 4096, 1023, 1));
		send_word(OP_RESOLVE, resolve_word(-32768, -32768, 1023, 1));
		send_word(OP_RESOLVE, resolve_word(32767, 32767, 1023, 1));
		send_word(OP_RESOLVE, resolve_word(-32768, 32767, 1, 1));
		send_word(OP_RESOLVE, resolve_word(0, 0, 1023, 1));
		send_word(OP_RESOLVE, resolve_word(6000, 6000, 700, 1));
		send_word(OP_RESOLVE, resolve_word(-10, 5000, 600, 1));
		send_word(OP_WRITE, write_word(0, 0, 1));
		send_word(OP_RESOLVE, resolve_word(128, 128, 1, 1));

		// register settings: reset value, smallest, zero, beyond store, random
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_MAP_WIDTH, 7'd1);
					write_reg(REG_MAP_HEIGHT, 7'd1);
				end
				1: begin
					write_reg(REG_MAP_WIDTH, 7'd0);
					write_reg(REG_MAP_HEIGHT, 7'd64);
				end
				2: begin
					write_reg(REG_MAP_WIDTH, 7'd127);
					write_reg(REG_MAP_HEIGHT, 7'd127);
				end
				3: begin
					write_reg(REG_MAP_WIDTH, 7'd64);
					write_reg(REG_MAP_HEIGHT, 7'd0);
				end
				4: begin
					write_reg(REG_MAP_WIDTH, 7'($urandom_range(1, 64)));
					write_reg(REG_MAP_HEIGHT, 7'($urandom_range(1, 64)));
				end
				default: begin
					write_reg(REG_MAP_WIDTH, 7'd64);
					write_reg(REG_MAP_HEIGHT, 7'd64);
				end
			endcase
			// one phase runs with no idling at all
			idling = (ph != 5);
			for (int i = 0; i < (ph == 5 ? 300 : 80); i++)
				random_item();
		end
		s_tvalid <= 0;
		idling = 1;

		while (sb.centre_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("circle_tile_collision_pushout: match");
		else
			$display("circle_tile_collision_pushout: mismatch");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/ctcp_pkg.sv
hw/rtl/ctcp_datapath.sv
hw/rtl/ctcp_ctrl.sv
hw/rtl/circle_tile_collision_pushout.sv
hw/rtl/ctcp_checker.sv
tb/circle_tile_collision_pushout_tb.sv
